// File: hdl/color_ramp_interpolator_assert.svh
`ifndef COLOR_RAMP_INTERPOLATOR_ASSERT_SVH
`define COLOR_RAMP_INTERPOLATOR_ASSERT_SVH

// Checks that a condition in the same cycle implies another one.
`define CRI_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("color ramp assertion failed");

// Checks that a condition implies another one in the next cycle.
`define CRI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("color ramp assertion failed");

`endif

// File: hdl/cri_pkg.sv
package cri_pkg;

    localparam int DEF_MAX_STOPS     = 16;
    localparam int DEF_VALUE_BITS    = 16;
    localparam int DEF_FRACTION_BITS = 8;

    localparam int COLOR_BITS     = 24;
    localparam int CHAN_BITS      = 8;
    localparam int INDEX_BITS     = 4;
    localparam int COUNT_BITS     = 5;
    localparam int CFG_INDEX_BITS = 4;
    localparam int OUT_BITS       = 4 * CHAN_BITS;

    localparam logic [CHAN_BITS-1:0] FULL_ALPHA = 8'd255;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] STATUS_INSIDE  = 2'd0;
    localparam logic [1:0] STATUS_BELOW   = 2'd1;
    localparam logic [1:0] STATUS_ABOVE   = 2'd2;
    localparam logic [1:0] STATUS_INVALID = 2'd3;

    localparam logic [1:0] MODE_END_STOPS = 2'd0;
    localparam logic [1:0] MODE_FALLBACK  = 2'd1;
    localparam logic [1:0] MODE_OWN       = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_LOWEST       = 4'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HIGHEST      = 4'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_STOP_COUNT   = 4'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_OUTSIDE_MODE = 4'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BELOW_COLOR  = 4'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ABOVE_COLOR  = 4'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FALLBACK     = 4'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TRANSPARENCY = 4'd7;

    localparam int                    RST_LOWEST       = 0;
    localparam int                    RST_HIGHEST      = 256;
    localparam logic [COUNT_BITS-1:0] RST_STOP_COUNT   = 5'd2;
    localparam logic [COLOR_BITS-1:0] RST_BELOW_COLOR  = 24'hFFFFFF;
    localparam logic [COLOR_BITS-1:0] RST_ABOVE_COLOR  = 24'hFF0000;
    localparam logic [COLOR_BITS-1:0] RST_FALLBACK     = 24'hFFFFFF;
    localparam logic [CHAN_BITS-1:0]  RST_TRANSPARENCY = 8'd0;

endpackage

// File: hdl/cri_divider.sv
module cri_divider
    import cri_pkg::*;
#(
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int STOP_BITS     = 4,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    parameter int SIDE_BITS     = 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [VALUE_BITS+STOP_BITS-1:0]     in_num,
    input  logic [VALUE_BITS-1:0]               in_den,
    input  logic [SIDE_BITS-1:0]                in_side,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [STOP_BITS+FRACTION_BITS-1:0]  out_quot,
    output logic [SIDE_BITS-1:0]                out_side
);

    localparam int QB = STOP_BITS + FRACTION_BITS;

    // The dividend is in_num scaled by the fraction; its top bits start as the
    // remainder, and each stage produces one quotient bit.
    logic [VALUE_BITS-1:0] rem_reg  [QB];
    logic [QB-1:0]         quo_reg  [QB];
    logic [SIDE_BITS-1:0]  side_reg [QB];
    logic [QB-1:0]         vld_reg;
    logic [QB:0]           rdy;

    assign rdy[QB]   = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[QB-1];
    assign out_quot  = quo_reg[QB-1];
    assign out_side  = side_reg[QB-1];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [VALUE_BITS-1:0] rem_in;
        logic [QB-1:0]         quo_in;
        logic [SIDE_BITS-1:0]  side_in;
        logic                  vld_in;
        logic [VALUE_BITS:0]   trial;
        logic [VALUE_BITS:0]   diff;
        logic                  fits;
        logic [VALUE_BITS-1:0] rem_next;
        logic [QB-1:0]         quo_next;

        if (k == 0) begin : g_first
            assign rem_in  = in_num[VALUE_BITS+STOP_BITS-1:STOP_BITS];
            assign quo_in  = {in_num[STOP_BITS-1:0], {FRACTION_BITS{1'b0}}};
            assign side_in = in_side;
            assign vld_in  = in_valid;
        end
        else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
            assign vld_in  = vld_reg[k-1];
        end

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        always_comb
        begin
            trial    = {rem_in, quo_in[QB-1]};
            diff     = trial - {1'b0, in_den};
            fits     = trial >= {1'b0, in_den};
            rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
            quo_next = {quo_in[QB-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vld_in)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

endmodule

// File: hdl/color_ramp_interpolator.sv
// Color ramp lookup: a lookup item maps a signed fixed-point sample onto a ramp of evenly
// spaced RGB stops and gives one result item, and a write item stores one stop and gives
// none. The block takes one item in every cycle while the output is not stalled. Its
// pipeline is the classify and multiply stages, the restoring divider, which resolves
// one quotient bit per pipeline stage and whose STOP_BITS is the address width of the
// stop table, and the stop table read and blend stages. Stalls on the output are absorbed
// by empty stages before the input is held off. Configuration writes are taken in any
// cycle but must only be made while no item is in flight.
module color_ramp_interpolator
    import cri_pkg::*;
#(
    parameter int MAX_STOPS     = DEF_MAX_STOPS,
    parameter int VALUE_BITS    = DEF_VALUE_BITS,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int CFG_BITS = (VALUE_BITS > COLOR_BITS) ? VALUE_BITS : COLOR_BITS,
    localparam int IN_BITS  = ((INDEX_BITS + COLOR_BITS + VALUE_BITS + 7) / 8) * 8
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_BITS-1:0]        s_tdata,  // stop_index, stop_color, sample_value
    input  logic                      s_tuser,  // operation
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_BITS-1:0]       m_tdata,  // red, green, blue, alpha
    output logic [1:0]                m_tuser   // range_status
);

`include "color_ramp_interpolator_assert.svh"

    localparam int SB         = $clog2(MAX_STOPS);
    localparam int QB         = SB + FRACTION_BITS;
    localparam int CNT_BITS   = (SB + 1 > COUNT_BITS) ? SB + 1 : COUNT_BITS;
    localparam int IDX_EXT    = SB + INDEX_BITS;
    localparam int COLOR_LSB  = INDEX_BITS;
    localparam int SAMPLE_LSB = INDEX_BITS + COLOR_BITS;
    localparam int BW         = CHAN_BITS + FRACTION_BITS + 2;

    typedef struct packed {
        logic                  lookup;
        logic                  wr_en;
        logic [SB-1:0]         addr;
        logic [COLOR_BITS-1:0] color;
        logic [1:0]            status;
        logic [SB-1:0]         n;
    } side_t;

    localparam int SIDE_BITS = $bits(side_t);

    logic [VALUE_BITS-1:0] lowest_reg;
    logic [VALUE_BITS-1:0] highest_reg;
    logic [VALUE_BITS-1:0] range_reg;
    logic [COUNT_BITS-1:0] stop_count_reg;
    logic [1:0]            outside_mode_reg;
    logic [COLOR_BITS-1:0] below_color_reg;
    logic [COLOR_BITS-1:0] above_color_reg;
    logic [COLOR_BITS-1:0] fallback_reg;
    logic [CHAN_BITS-1:0]  transparency_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lowest_reg       <= VALUE_BITS'(RST_LOWEST);
            highest_reg      <= VALUE_BITS'(RST_HIGHEST);
            range_reg        <= VALUE_BITS'(RST_HIGHEST - RST_LOWEST);
            stop_count_reg   <= RST_STOP_COUNT;
            outside_mode_reg <= MODE_END_STOPS;
            below_color_reg  <= RST_BELOW_COLOR;
            above_color_reg  <= RST_ABOVE_COLOR;
            fallback_reg     <= RST_FALLBACK;
            transparency_reg <= RST_TRANSPARENCY;
        end
        else
        begin
            range_reg <= highest_reg - lowest_reg;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_LOWEST:       lowest_reg       <= cfg_data[VALUE_BITS-1:0];
                    REG_HIGHEST:      highest_reg      <= cfg_data[VALUE_BITS-1:0];
                    REG_STOP_COUNT:   stop_count_reg   <= cfg_data[COUNT_BITS-1:0];
                    REG_OUTSIDE_MODE: outside_mode_reg <= cfg_data[1:0];
                    REG_BELOW_COLOR:  below_color_reg  <= cfg_data[COLOR_BITS-1:0];
                    REG_ABOVE_COLOR:  above_color_reg  <= cfg_data[COLOR_BITS-1:0];
                    REG_FALLBACK:     fallback_reg     <= cfg_data[COLOR_BITS-1:0];
                    REG_TRANSPARENCY: transparency_reg <= cfg_data[CHAN_BITS-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Classify stage.
    logic                  rdy_0;
    logic                  rdy_1;
    logic                  rdy_m;
    logic                  rdy_o;
    logic                  p0_vld_reg;
    side_t                 p0_side_reg;
    logic [VALUE_BITS-1:0] p0_d_reg;
    side_t                 p0_side_next;
    logic [VALUE_BITS-1:0] p0_d_next;
    logic [CNT_BITS-1:0]   cnt_ext;
    logic [CNT_BITS-1:0]   cnt_clamp;
    logic                  setup_bad;
    logic [VALUE_BITS-1:0] sample;
    logic [VALUE_BITS:0]   sample_diff;
    logic [IDX_EXT-1:0]    idx_ext;

    always_comb
    begin
        cnt_ext     = CNT_BITS'(stop_count_reg);
        cnt_clamp   = (cnt_ext > CNT_BITS'(MAX_STOPS)) ? CNT_BITS'(MAX_STOPS) : cnt_ext;
        setup_bad   = (cnt_clamp < CNT_BITS'(2))
                   || ($signed(highest_reg) <= $signed(lowest_reg));
        sample      = s_tdata[SAMPLE_LSB +: VALUE_BITS];
        sample_diff = {sample[VALUE_BITS-1], sample}
                    - {lowest_reg[VALUE_BITS-1], lowest_reg};
        idx_ext     = IDX_EXT'(s_tdata[INDEX_BITS-1:0]);

        p0_side_next.lookup = (s_tuser == OP_LOOKUP);
        p0_side_next.wr_en  = (s_tuser == OP_WRITE) && (idx_ext < IDX_EXT'(MAX_STOPS));
        p0_side_next.addr   = idx_ext[SB-1:0];
        p0_side_next.color  = s_tdata[COLOR_LSB +: COLOR_BITS];
        p0_side_next.n      = SB'(cnt_clamp - CNT_BITS'(1));
        if (setup_bad)
        begin
            p0_side_next.status = STATUS_INVALID;
        end
        else if ($signed(sample) < $signed(lowest_reg))
        begin
            p0_side_next.status = STATUS_BELOW;
        end
        else if ($signed(sample) > $signed(highest_reg))
        begin
            p0_side_next.status = STATUS_ABOVE;
        end
        else
        begin
            p0_side_next.status = STATUS_INSIDE;
        end
        p0_d_next = sample_diff[VALUE_BITS-1:0];
    end

    assign rdy_0    = !p0_vld_reg || rdy_1;
    assign s_tready = rdy_0;

    // Multiply stage.
    logic                     p1_vld_reg;
    side_t                    p1_side_reg;
    logic [VALUE_BITS+SB-1:0] p1_prod_reg;
    logic [VALUE_BITS+SB-1:0] p1_prod_next;
    logic                     div_in_ready;

    assign p1_prod_next = (VALUE_BITS+SB)'(p0_d_reg) * (VALUE_BITS+SB)'(p0_side_reg.n);
    assign rdy_1        = !p1_vld_reg || div_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy_0)
            begin
                p0_vld_reg <= s_tvalid;
            end
            if (rdy_1)
            begin
                p1_vld_reg <= p0_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_0 && s_tvalid)
        begin
            p0_side_reg <= p0_side_next;
            p0_d_reg    <= p0_d_next;
        end
        if (rdy_1 && p0_vld_reg)
        begin
            p1_side_reg <= p0_side_reg;
            p1_prod_reg <= p1_prod_next;
        end
    end

    // Divide stages.
    logic                 div_out_valid;
    logic [QB-1:0]        div_quot;
    logic [SIDE_BITS-1:0] div_side_bits;
    side_t                dv_side;

    cri_divider #(
        .VALUE_BITS    (VALUE_BITS),
        .STOP_BITS     (SB),
        .FRACTION_BITS (FRACTION_BITS),
        .SIDE_BITS     (SIDE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (p1_vld_reg),
        .in_ready  (div_in_ready),
        .in_num    (p1_prod_reg),
        .in_den    (range_reg),
        .in_side   (p1_side_reg),
        .out_valid (div_out_valid),
        .out_ready (rdy_m),
        .out_quot  (div_quot),
        .out_side  (div_side_bits)
    );

    assign dv_side = div_side_bits;

    // Stop table stage: writes land here so that they stay in order with lookups.
    logic [COLOR_BITS-1:0]    stop_mem [MAX_STOPS];
    logic                     pm_vld_reg;
    logic [COLOR_BITS-1:0]    pm_ca_reg;
    logic [COLOR_BITS-1:0]    pm_cb_reg;
    logic [FRACTION_BITS-1:0] pm_f_reg;
    logic [1:0]               pm_status_reg;
    logic [SB-1:0]            lo_raw;
    logic [SB-1:0]            lo_clamp;
    logic [SB-1:0]            hi_addr;
    logic [SB-1:0]            rd_addr_next;
    logic [FRACTION_BITS-1:0] pm_f_next;
    logic                     pm_load;

    always_comb
    begin
        lo_raw   = div_quot[QB-1:FRACTION_BITS];
        lo_clamp = (lo_raw > dv_side.n) ? dv_side.n : lo_raw;
        hi_addr  = (lo_clamp < dv_side.n) ? lo_clamp + SB'(1) : lo_clamp;
        case (dv_side.status)
            STATUS_BELOW: rd_addr_next = '0;
            STATUS_ABOVE: rd_addr_next = dv_side.n;
            default:      rd_addr_next = lo_clamp;
        endcase
        pm_f_next = (dv_side.status == STATUS_INSIDE) ? div_quot[FRACTION_BITS-1:0] : '0;
    end

    assign rdy_m   = !pm_vld_reg || rdy_o;
    assign pm_load = rdy_m && div_out_valid;

    always_ff @(posedge clk)
    begin
        if (pm_load)
        begin
            if (dv_side.wr_en)
            begin
                stop_mem[dv_side.addr] <= dv_side.color;
            end
            pm_ca_reg     <= stop_mem[rd_addr_next];
            pm_cb_reg     <= stop_mem[hi_addr];
            pm_f_reg      <= pm_f_next;
            pm_status_reg <= dv_side.status;
        end
    end

    // Blend and output stage.
    logic                  po_vld_reg;
    logic [COLOR_BITS-1:0] po_rgb_reg;
    logic [CHAN_BITS-1:0]  po_alpha_reg;
    logic [1:0]            po_status_reg;
    logic [COLOR_BITS-1:0] blend_rgb;
    logic [COLOR_BITS-1:0] po_rgb_next;
    logic [BW-1:0]         ca_w;
    logic [BW-1:0]         cb_w;
    logic [BW-1:0]         f_w;
    logic [BW-1:0]         mix;

    always_comb
    begin
        blend_rgb = '0;
        f_w       = BW'(pm_f_reg);
        ca_w      = '0;
        cb_w      = '0;
        mix       = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            ca_w = BW'(pm_ca_reg[ch*CHAN_BITS +: CHAN_BITS]);
            cb_w = BW'(pm_cb_reg[ch*CHAN_BITS +: CHAN_BITS]);
            mix  = ca_w * ((BW'(1) << FRACTION_BITS) - f_w) + cb_w * f_w
                 + (BW'(1) << (FRACTION_BITS - 1));
            blend_rgb[ch*CHAN_BITS +: CHAN_BITS] = mix[FRACTION_BITS +: CHAN_BITS];
        end

        if (pm_status_reg == STATUS_INVALID)
        begin
            po_rgb_next = '0;
        end
        else if (pm_status_reg == STATUS_INSIDE)
        begin
            po_rgb_next = blend_rgb;
        end
        else
        begin
            case (outside_mode_reg)
                MODE_END_STOPS: po_rgb_next = blend_rgb;
                MODE_FALLBACK:  po_rgb_next = fallback_reg;
                default:        po_rgb_next = (pm_status_reg == STATUS_BELOW)
                                            ? below_color_reg : above_color_reg;
            endcase
        end
    end

    assign rdy_o = !po_vld_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_vld_reg <= 1'b0;
            po_vld_reg <= 1'b0;
        end
        else
        begin
            if (rdy_m)
            begin
                pm_vld_reg <= div_out_valid && dv_side.lookup;
            end
            if (rdy_o)
            begin
                po_vld_reg <= pm_vld_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o && pm_vld_reg)
        begin
            po_rgb_reg    <= po_rgb_next;
            po_alpha_reg  <= FULL_ALPHA - transparency_reg;
            po_status_reg <= pm_status_reg;
        end
    end

    assign m_tvalid = po_vld_reg;
    assign m_tdata  = {po_alpha_reg, po_rgb_reg[7:0], po_rgb_reg[15:8], po_rgb_reg[23:16]};
    assign m_tuser  = po_status_reg;

    `CRI_ASSERT_IMPL(a_invalid_black, m_tvalid && (m_tuser == STATUS_INVALID), m_tdata[23:0] == '0)
    `CRI_ASSERT_IMPL(a_alpha_tracks, m_tvalid, m_tdata[31:24] == FULL_ALPHA - transparency_reg)
    `CRI_ASSERT_IMPL(a_empty_out_ready, !m_tvalid, s_tready)
    `CRI_ASSERT_NEXT(a_write_silent, pm_load && !dv_side.lookup, !pm_vld_reg)

endmodule
